// ===== hdl/acestc_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ACES filmic tone curve package
// Widths, curve coefficients and shared types for the tone curve pipeline.
// ---------------------------------------------------------------------------
package acestc_pkg;

    localparam int X_W          = 24;               // unsigned Q8.16 radiance
    localparam int Y_W          = 16;               // unsigned Q0.16 result
    localparam int POLY_W       = 32;               // c2 * x + c1 * 2^16
    localparam int PROD_W       = 56;               // numerator / denominator
    localparam int M_W          = PROD_W + Y_W + 1; // 131070 * num + den
    localparam int DIV_W        = PROD_W + 1;       // divisor 2 * den
    localparam int DIV_STEPS    = Y_W;              // one quotient bit per step
    localparam int FRONT_STAGES = 3;
    localparam int LANE_STAGES  = FRONT_STAGES + DIV_STEPS;
    localparam int PIPE_STAGES  = LANE_STAGES + 1;
    localparam int LANES        = 3;

    // Coefficients as exact hundredths, common scale cancelled.
    localparam logic [POLY_W-1:0] C_NUM_SQ  = POLY_W'(251);
    localparam logic [POLY_W-1:0] C_NUM_LIN = POLY_W'(3) << 16;
    localparam logic [POLY_W-1:0] C_DEN_SQ  = POLY_W'(243);
    localparam logic [POLY_W-1:0] C_DEN_LIN = POLY_W'(59) << 16;
    localparam logic [PROD_W-1:0] C_DEN_OFS = PROD_W'(14) << 32;

    localparam logic [Y_W-1:0] Y_MAX = '1;

    typedef struct packed {
        logic [X_W-1:0] red_in;
        logic [X_W-1:0] green_in;
        logic [X_W-1:0] blue_in;
    } t_pix_in;

    typedef struct packed {
        logic [Y_W-1:0] red_out;
        logic [Y_W-1:0] green_out;
        logic [Y_W-1:0] blue_out;
    } t_pix_out;

    // Restoring division state carried down the step chain.
    typedef struct packed {
        logic             sat;
        logic [DIV_W-1:0] rem;
        logic [Y_W-1:0]   low;
        logic [Y_W-1:0]   quo;
        logic [DIV_W-1:0] dvs;
    } t_div_st;

endpackage

// ===== hdl/acestc_stream_if.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Stream channel
// Valid/ready channel with a typed payload; one transfer per cycle at most.
// ---------------------------------------------------------------------------
interface acestc_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (
        output valid,
        output payload,
        input  ready
    );

    modport sink (
        input  valid,
        input  payload,
        output ready
    );
endinterface

// ===== hdl/aces_filmic_tone_curve.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ACES filmic tone curve
// Maps HDR RGB pixels (unsigned Q8.16) to display range (unsigned Q0.16).
// ---------------------------------------------------------------------------
// Usage:
//   i_pix carries one pixel per transfer, three Q8.16 channels; o_pix
//   returns the tone-mapped pixel, three 16-bit channels, 65535 = 1.0.
//   Three identical lanes process red, green and blue side by side; the
//   output register merges their results into one pixel.
//   From the input transfer to the output transfer a pixel passes three
//   front stages (polynomials, 24x32 multiplies, dividend forming), sixteen
//   restoring-division steps of one quotient bit each, and the output
//   register. Throughput is one pixel per clock while the receiver does not
//   stall, set by the per-step 57-bit compare-subtract and the registered
//   multiplies.
//   Reset empties the pipeline; nothing else needs clearing.
//   When the receiver stalls, bubbles in the pipeline still close up, so
//   i_pix.ready drops only once all 20 stages hold a pixel.
//   Pixels leave in the order they arrive.
// ---------------------------------------------------------------------------
module aces_filmic_tone_curve (
    input  logic          i_clk,
    input  logic          i_rst_n,
    acestc_stream_if.sink   i_pix,
    acestc_stream_if.source o_pix
);
    import acestc_pkg::*;

    localparam int LAST = PIPE_STAGES - 1;

    logic [PIPE_STAGES-1:0] r_vld;
    logic [PIPE_STAGES-1:0] n_vld;
    logic [PIPE_STAGES-1:0] w_rdy;
    logic [X_W-1:0]         w_x [LANES];
    logic [Y_W-1:0]         w_y [LANES];
    t_pix_out               r_out;

    assign w_x[0] = i_pix.payload.red_in;
    assign w_x[1] = i_pix.payload.green_in;
    assign w_x[2] = i_pix.payload.blue_in;

    for (genvar l = 0; l < LANES; l++) begin : g_lane
        acestc_lane u_lane (
            .i_clk (i_clk),
            .i_en  (w_rdy[LANE_STAGES-1:0]),
            .i_x   (w_x[l]),
            .o_y   (w_y[l])
        );
    end

    // A stage may load unless it and every stage after it is full and stalled.
    for (genvar k = 0; k < PIPE_STAGES; k++) begin : g_rdy
        assign w_rdy[k] = o_pix.ready || !(&r_vld[LAST:k]);
    end

    always_comb begin
        n_vld = r_vld;
        if (w_rdy[0]) begin
            n_vld[0] = i_pix.valid;
        end
        for (int k = 1; k < PIPE_STAGES; k++) begin
            if (w_rdy[k]) begin
                n_vld[k] = r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    // Merge the three lane results into one output pixel.
    always_ff @(posedge i_clk) begin
        if (w_rdy[LAST]) begin
            r_out.red_out   <= w_y[0];
            r_out.green_out <= w_y[1];
            r_out.blue_out  <= w_y[2];
        end
    end

    assign i_pix.ready   = w_rdy[0];
    assign o_pix.valid   = r_vld[LAST];
    assign o_pix.payload = r_out;

    // An empty output stage never blocks the input.
    a_rdy_when_out_empty : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_vld[LAST] |-> i_pix.ready)
        else $error("input blocked with output stage empty");

    // Backpressure reaches the input only with every stage full.
    a_stall_only_when_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_pix.ready |-> (&r_vld) && !o_pix.ready)
        else $error("input stalled with a bubble in the pipeline");

    // A transfer in lands in the first stage.
    a_accept_fills_first : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pix.valid && i_pix.ready |=> r_vld[0])
        else $error("accepted pixel lost at first stage");

    // A stalled output keeps its pixel and every stage stays full.
    a_full_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (&r_vld) && !o_pix.ready |=> (&r_vld))
        else $error("pipeline stage dropped during stall");

endmodule

// ===== hdl/acestc_div_step.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Tone curve divider step
// One registered restoring-division step: brings in one dividend bit and
// produces one quotient bit.
// ---------------------------------------------------------------------------
module acestc_div_step (
    input  logic                i_clk,
    input  logic                i_en,
    input  acestc_pkg::t_div_st i_st,
    output acestc_pkg::t_div_st o_st
);
    import acestc_pkg::*;

    logic [DIV_W:0] w_trial;
    logic           w_ge;
    t_div_st        n_st;
    t_div_st        r_st;

    always_comb begin
        w_trial  = {i_st.rem, i_st.low[Y_W-1]};
        w_ge     = (w_trial >= {1'b0, i_st.dvs});
        n_st     = i_st;
        n_st.rem = w_ge ? DIV_W'(w_trial - {1'b0, i_st.dvs}) : w_trial[DIV_W-1:0];
        n_st.low = {i_st.low[Y_W-2:0], 1'b0};
        n_st.quo = {i_st.quo[Y_W-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st <= n_st;
        end
    end

    assign o_st = r_st;

endmodule

// ===== hdl/acestc_lane.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Tone curve lane
// Maps one channel through x(2.51x+0.03)/(x(2.43x+0.59)+0.14), clamped to 1.0
// and rounded to nearest on a 65535 scale.
// ---------------------------------------------------------------------------
module acestc_lane (
    input  logic                               i_clk,
    input  logic [acestc_pkg::LANE_STAGES-1:0] i_en,
    input  logic [acestc_pkg::X_W-1:0]         i_x,
    output logic [acestc_pkg::Y_W-1:0]         o_y
);
    import acestc_pkg::*;

    logic [X_W-1:0]    r_x;
    logic [POLY_W-1:0] r_a;
    logic [POLY_W-1:0] r_b;
    logic [PROD_W-1:0] r_num;
    logic [PROD_W-1:0] r_den;
    logic [M_W-1:0]    w_m;
    t_div_st           n_div0;
    t_div_st           r_div0;
    t_div_st [DIV_STEPS:0] w_chain;

    // Inner polynomials
    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_x <= i_x;
            r_a <= POLY_W'(i_x) * C_NUM_SQ + C_NUM_LIN;
            r_b <= POLY_W'(i_x) * C_DEN_SQ + C_DEN_LIN;
        end
    end

    // Numerator and denominator
    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_num <= PROD_W'(r_x) * PROD_W'(r_a);
            r_den <= PROD_W'(r_x) * PROD_W'(r_b) + C_DEN_OFS;
        end
    end

    // Dividend 131070 * num + den, divisor 2 * den; the extra den rounds.
    always_comb begin
        w_m = (M_W'(r_num) << (Y_W + 1)) - (M_W'(r_num) << 1) + M_W'(r_den);
        n_div0.sat = (r_num >= r_den);
        n_div0.rem = w_m[M_W-1:Y_W];
        n_div0.low = w_m[Y_W-1:0];
        n_div0.quo = '0;
        n_div0.dvs = {r_den, 1'b0};
    end

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_div0 <= n_div0;
        end
    end

    assign w_chain[0] = r_div0;

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
        acestc_div_step u_step (
            .i_clk (i_clk),
            .i_en  (i_en[FRONT_STAGES+k]),
            .i_st  (w_chain[k]),
            .o_st  (w_chain[k+1])
        );
    end

    assign o_y = w_chain[DIV_STEPS].sat ? Y_MAX : w_chain[DIV_STEPS].quo;

endmodule

// ===== test/tb_aces_filmic_tone_curve.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ACES filmic tone curve testbench
// Streams HDR pixels through the tone curve with random idling on both
// channels and compares every output pixel, channel by channel, with an
// exact fixed-point evaluation of the curve, clamp and rounding.
// ---------------------------------------------------------------------------
module tb_aces_filmic_tone_curve;

    import acestc_pkg::*;

    localparam int HALF_PERIOD   = 5;
    localparam int RANDOM_PIXELS = 1900;
    localparam int IDLE_LIMIT    = 2000;   // cycles with no transfer on either side
    localparam int TAIL_CYCLES   = 40;     // well past the pipeline latency
    localparam int PRESSURE_HOLD = 120;    // receiver hold-off, well past pipeline depth
    localparam int KNEE_X        = 474585; // curve crosses 1.0 near this raw input

    // -----------------------------------------------------------------------
    // Expected pixels and the curve they come from
    // -----------------------------------------------------------------------
    class tone_scoreboard;
        t_pix_out expected_pix[$];
        int       pixels_in;
        int       pixels_out;
        int       mismatches;
        int       clamped_channels;
        int       zero_channels;

        // Exact curve value: 65535 * num / den, rounded to nearest, ties up.
        function automatic logic [Y_W-1:0] tone_value(logic [X_W-1:0] x);
            logic [63:0]  xv;
            logic [63:0]  num;
            logic [63:0]  den;
            logic [127:0] dividend;
            logic [127:0] quo;
            xv  = 64'(x);
            num = xv * (64'd251 * xv + (64'd3 << 16));
            den = xv * (64'd243 * xv + (64'd59 << 16)) + (64'd14 << 32);
            if (num >= den) begin
                return '1;
            end
            dividend = 128'(num) * 128'd131070 + 128'(den);
            quo      = dividend / (128'(den) << 1);
            if (quo > 128'd65535) begin
                return '1;
            end
            return quo[Y_W-1:0];
        endfunction

        function void note_pixel(t_pix_in p);
            t_pix_out e;
            e.red_out   = tone_value(p.red_in);
            e.green_out = tone_value(p.green_in);
            e.blue_out  = tone_value(p.blue_in);
            clamped_channels += (e.red_out == '1) + (e.green_out == '1) + (e.blue_out == '1);
            zero_channels    += (e.red_out == '0) + (e.green_out == '0) + (e.blue_out == '0);
            expected_pix.push_back(e);
            pixels_in++;
        endfunction

        function void check_pixel(t_pix_out got);
            t_pix_out e;
            pixels_out++;
            if (expected_pix.size() == 0) begin
                $error("output pixel with none pending: r=%0d g=%0d b=%0d",
                       got.red_out, got.green_out, got.blue_out);
                mismatches++;
                return;
            end
            e = expected_pix.pop_front();
            if (got.red_out !== e.red_out) begin
                $error("red_out: expected %0d, got %0d", e.red_out, got.red_out);
                mismatches++;
            end
            if (got.green_out !== e.green_out) begin
                $error("green_out: expected %0d, got %0d", e.green_out, got.green_out);
                mismatches++;
            end
            if (got.blue_out !== e.blue_out) begin
                $error("blue_out: expected %0d, got %0d", e.blue_out, got.blue_out);
                mismatches++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    acestc_stream_if #(.t_payload(t_pix_in))  pix_in_ch ();
    acestc_stream_if #(.t_payload(t_pix_out)) pix_out_ch ();

    aces_filmic_tone_curve dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_in_ch),
        .o_pix   (pix_out_ch)
    );

    tone_scoreboard sb;
    bit             hold_request;
    int             idle_cycles;

    always begin
        #HALF_PERIOD i_clk = 1'b1;
        #HALF_PERIOD i_clk = 1'b0;
    end

    // Mostly no gap, some short, a few long.
    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [X_W-1:0] random_channel();
        int mode;
        mode = $urandom_range(0, 9);
        case (mode)
            0, 1, 2: begin
                return X_W'($urandom);
            end
            3, 4: begin
                return X_W'($urandom_range(0, 1 << 16));          // up to 1.0
            end
            5, 6: begin
                return X_W'($urandom_range(0, 8 << 16));          // up to 8.0
            end
            7: begin
                return X_W'($urandom_range(KNEE_X - 300, KNEE_X + 300));
            end
            8: begin
                case ($urandom_range(0, 3))
                    0: return '0;
                    1: return X_W'(1);
                    2: return '1;
                    default: return X_W'(24'hFFFFFE);
                endcase
            end
            default: begin
                return X_W'($urandom_range(0, 1 << 20));
            end
        endcase
    endfunction

    // Offer one pixel after an optional gap and hold it until the transfer.
    task automatic send_pixel(input t_pix_in p, input int gap);
        if (gap > 0) begin
            pix_in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pix_in_ch.valid   <= 1'b1;
        pix_in_ch.payload <= p;
        do @(posedge i_clk); while (!pix_in_ch.ready);
    endtask

    task automatic send_directed();
        send_pixel('{24'h000000, 24'h000000, 24'h000000}, 0);
        send_pixel('{24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF}, 0);
        send_pixel('{24'h000001, 24'hFFFFFE, 24'h010000}, 0);
        send_pixel('{24'h800000, 24'h7FFFFF, 24'h00FFFF}, 1);
        send_pixel('{24'h000002, 24'h000003, 24'hAAAAAA}, 0);
        send_pixel('{24'h555555, 24'h0F0F0F, 24'hF0F0F0}, 0);
        send_pixel('{24'h008000, 24'h004000, 24'h020000}, 2);
        send_pixel('{24'h070000, 24'h080000, 24'h0FFFFF}, 0);
        for (int k = 0; k < 8; k++) begin
            send_pixel('{X_W'(KNEE_X - 4 + k), X_W'(KNEE_X + k), X_W'(KNEE_X + 4 + k)}, 0);
        end
        send_pixel('{24'hFFFF00, 24'h00FF00, 24'h0000FF}, 0);
        send_pixel('{24'h000000, 24'hFFFFFF, 24'h000000}, 0);
    endtask

    task automatic send_random();
        t_pix_in p;
        int      gap;
        for (int n = 0; n < RANDOM_PIXELS; n++) begin
            p.red_in   = random_channel();
            p.green_in = random_channel();
            p.blue_in  = random_channel();
            gap = idle_gap();
            // Back-to-back stretches: one under a receiver hold-off, one free-running.
            if (n >= 600 && n < 750) begin
                gap = 0;
                if (n == 600) begin
                    hold_request = 1'b1;
                end
            end
            if (n >= 1200 && n < 1400) begin
                gap = 0;
            end
            send_pixel(p, gap);
        end
        pix_in_ch.valid <= 1'b0;
    endtask

    // Receiver: random ready pattern, plus one long hold-off on request.
    initial begin
        int gap;
        pix_out_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                pix_out_ch.ready <= 1'b0;
                repeat (PRESSURE_HOLD) @(posedge i_clk);
            end else begin
                pix_out_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge i_clk);
                gap = idle_gap();
                if (gap > 0) begin
                    pix_out_ch.ready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
        end
    end

    // Note inputs before checking outputs so a combinational input-to-output path would still match.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (pix_in_ch.valid && pix_in_ch.ready) begin
                sb.note_pixel(pix_in_ch.payload);
            end
            if (pix_out_ch.valid && pix_out_ch.ready) begin
                sb.check_pixel(pix_out_ch.payload);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (pix_in_ch.valid && pix_in_ch.ready)
                     || (pix_out_ch.valid && pix_out_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", idle_cycles);
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        sb = new();
        hold_request = 1'b0;
        idle_cycles = 0;
        i_rst_n           <= 1'b0;
        pix_in_ch.valid   <= 1'b0;
        pix_in_ch.payload <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_directed();
        send_random();

        // Drain, then watch a while longer for stray outputs.
        while (sb.expected_pix.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("%0d pixels in, %0d out; %0d channels clamped to full scale, %0d at zero",
                 sb.pixels_in, sb.pixels_out, sb.clamped_channels, sb.zero_channels);
        $display("covered zero and full-range inputs, the clamp knee and a long output stall");
        if (sb.mismatches == 0 && sb.expected_pix.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
